[src/tma_pkg.sv]
// shared types and constants for the trimmed moving average filter
package tma_pkg;

  localparam int SMP_W = 16;

  typedef logic signed [SMP_W-1:0] smp_t;

  localparam smp_t SMP_MAX = 16'sh7fff;
  localparam smp_t SMP_MIN = 16'sh8000;

  // back end sequencer codes
  localparam int ST_W = 3;
  localparam logic [ST_W-1:0] S_IDLE = 3'd0;
  localparam logic [ST_W-1:0] S_SCAN = 3'd1;
  localparam logic [ST_W-1:0] S_LAST = 3'd2;
  localparam logic [ST_W-1:0] S_TRIM = 3'd3;
  localparam logic [ST_W-1:0] S_ABS  = 3'd4;
  localparam logic [ST_W-1:0] S_MUL  = 3'd5;
  localparam logic [ST_W-1:0] S_OUT  = 3'd6;

endpackage

[src/tma_ram.sv]
// generic single-write, single-read ram with registered read data
module tma_ram #(
  parameter int DW    = 16,
  parameter int DEPTH = 10
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DW-1:0]            wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DW-1:0]            rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/tma_front.sv]
// input side: takes samples and tags each with its window slot
module tma_front #(
  parameter int WINDOW = 10
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  tma_pkg::smp_t             in_sample,
  input  logic                      q_full,
  output logic                      q_push,
  output logic [$clog2(WINDOW)-1:0] q_pos,
  output tma_pkg::smp_t             q_sample
);
  import tma_pkg::*;

  localparam int AW = $clog2(WINDOW);
  localparam logic [AW-1:0] LAST_POS = AW'(WINDOW - 1);

  logic [AW-1:0] pos_r;
  logic [AW-1:0] pos_nxt;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;
  assign q_pos    = pos_r;
  assign q_sample = in_sample;

  always_comb begin
    pos_nxt = pos_r;
    if (q_push) begin
      pos_nxt = (pos_r == LAST_POS) ? '0 : pos_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

endmodule

[src/tma_queue.sv]
// two-entry request queue between the front and back ends
module tma_queue #(
  parameter int DW = 20
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] push_data,
  input  logic          pop,
  output logic [DW-1:0] pop_data,
  output logic          full,
  output logic          empty
);

  logic [DW-1:0] slot_r [2];
  logic          wr_ptr_r;
  logic          rd_ptr_r;
  logic [1:0]    cnt_r;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign pop_data = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

[src/tma_back.sv]
// back end: window store, scan for max/min/sum, trimmed mean and output register
module tma_back #(
  parameter int WINDOW = 10
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_empty,
  input  logic [$clog2(WINDOW)-1:0] q_pos,
  input  tma_pkg::smp_t             q_sample,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output tma_pkg::smp_t             out_filtered
);
  import tma_pkg::*;

  localparam int AW  = $clog2(WINDOW);
  localparam int DIV = WINDOW - 2;
  localparam int SW  = $clog2(WINDOW) + SMP_W;
  localparam int TW  = SW + 1;
  // magnitude of the trimmed sum stays below 2^NW
  localparam int NW  = $clog2(DIV * 32768 + 1);
  localparam int LW  = $clog2(DIV);
  localparam int SH  = NW + LW;
  localparam int MW  = NW + 1;
  // rounded-up reciprocal, exact floor division for values below 2^NW
  localparam logic [MW-1:0] RECIP =
    MW'(((64'd1 << SH) + 64'(DIV) - 64'd1) / 64'(DIV));
  localparam logic [AW-1:0] LAST_K = AW'(WINDOW - 1);

  logic [ST_W-1:0]        state_r, state_nxt;
  logic [AW-1:0]          k_r;
  logic [WINDOW-1:0]      vld_r;
  logic                   rd_pend_r;
  logic                   rd_vld_r;
  logic                   ram_re;
  smp_t                   ram_rdata;
  smp_t                   cur_v;
  smp_t                   hi_r, lo_r;
  logic signed [SW-1:0]   sum_r;
  logic signed [TW-1:0]   trim_r;
  logic [NW-1:0]          mag_r;
  logic                   neg_r;
  logic [NW+MW-1:0]       prod_r;
  logic [SMP_W-1:0]       quo;
  logic                   out_valid_r;
  smp_t                   out_filt_r;
  logic                   out_free;

  assign q_pop    = (state_r == S_IDLE) && !q_empty;
  assign ram_re   = (state_r == S_SCAN);
  assign out_free = !out_valid_r || !out_stall;

  tma_ram #(
    .DW    (SMP_W),
    .DEPTH (WINDOW)
  ) u_ram (
    .clk   (clk),
    .we    (q_pop),
    .waddr (q_pos),
    .wdata (q_sample),
    .re    (ram_re),
    .raddr (k_r),
    .rdata (ram_rdata)
  );

  // entries never written since reset read as zero
  assign cur_v = rd_vld_r ? ram_rdata : '0;
  assign quo   = prod_r[SH +: SMP_W];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (!q_empty) state_nxt = S_SCAN;
      S_SCAN:  if (k_r == LAST_K) state_nxt = S_LAST;
      S_LAST:  state_nxt = S_TRIM;
      S_TRIM:  state_nxt = S_ABS;
      S_ABS:   state_nxt = S_MUL;
      S_MUL:   state_nxt = S_OUT;
      S_OUT:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vld_r       <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
      k_r         <= '0;
    end else begin
      state_r   <= state_nxt;
      rd_pend_r <= (state_r == S_SCAN);
      if (q_pop) begin
        vld_r[q_pos] <= 1'b1;
        k_r          <= '0;
      end else if (state_r == S_SCAN && k_r != LAST_K) begin
        k_r <= k_r + AW'(1);
      end
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_SCAN) begin
      rd_vld_r <= vld_r[k_r];
    end
    if (q_pop) begin
      hi_r  <= SMP_MIN;
      lo_r  <= SMP_MAX;
      sum_r <= '0;
    end else if (rd_pend_r) begin
      // max and min tracked independently
      if (cur_v > hi_r) hi_r <= cur_v;
      if (cur_v < lo_r) lo_r <= cur_v;
      sum_r <= sum_r + SW'(cur_v);
    end
    if (state_r == S_TRIM) begin
      trim_r <= TW'(sum_r) - TW'(hi_r) - TW'(lo_r);
    end
    if (state_r == S_ABS) begin
      neg_r <= trim_r[TW-1];
      mag_r <= trim_r[TW-1] ? NW'(-trim_r) : NW'(trim_r);
    end
    if (state_r == S_MUL) begin
      prod_r <= (NW+MW)'(mag_r) * (NW+MW)'(RECIP);
    end
    if (state_r == S_OUT && out_free) begin
      out_filt_r <= neg_r ? smp_t'(-quo) : smp_t'(quo);
    end
  end

  assign out_valid    = out_valid_r;
  assign out_filtered = out_filt_r;

endmodule

[src/trimmed_moving_average_filter.sv]
// trimmed moving average filter top level: front end, request queue, back end
// the back end finishes each sample, walking the window through the single read
//   port of the store, before it takes the next request from the queue
// the front takes up to two more samples while the back end works
// reset (synchronous, rst_n low) empties the queue, zeroes the write slot and
//   marks every window entry as zero
module trimmed_moving_average_filter #(
  parameter int WINDOW = 10
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  tma_pkg::smp_t in_sample,
  output logic          out_valid,
  input  logic          out_stall,
  output tma_pkg::smp_t out_filtered
);
  import tma_pkg::*;

  localparam int AW = $clog2(WINDOW);
  localparam int QW = SMP_W + AW;

  logic          q_push, q_pop, q_full, q_empty;
  logic [AW-1:0] f_pos;
  smp_t          f_sample;
  logic [QW-1:0] q_rd;

  tma_front #(
    .WINDOW (WINDOW)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_sample (in_sample),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_pos     (f_pos),
    .q_sample  (f_sample)
  );

  tma_queue #(
    .DW (QW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data ({f_pos, f_sample}),
    .pop       (q_pop),
    .pop_data  (q_rd),
    .full      (q_full),
    .empty     (q_empty)
  );

  tma_back #(
    .WINDOW (WINDOW)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .q_pos        (q_rd[QW-1:SMP_W]),
    .q_sample     (q_rd[SMP_W-1:0]),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_filtered (out_filtered)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("request pushed into a full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("back end popped an empty queue");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> !q_pop)
    else $error("back end took a new request while scanning");

endmodule

[tb/sv/trimmed_moving_average_filter_test.sv]
// self-checking testbench for the trimmed moving average filter
module trimmed_moving_average_filter_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tma_pkg::*;

  localparam int WIN = 10;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  smp_t in_sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  smp_t out_filtered;

  // predictor copy of the window
  smp_t ring [WIN];
  int unsigned slot;

  smp_t pending_filtered [$];
  smp_t want_filtered;
  int mismatch_count = 0;
  int stall_left = 0;
  bit steady_in = 1'b0;
  bit steady_out = 1'b0;

  trimmed_moving_average_filter #(.WINDOW(WIN)) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_sample(in_sample),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_filtered(out_filtered)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // mostly no gap, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // write the sample into the ring, then mean of the window less one max and one min
  function automatic smp_t trimmed_mean(input smp_t s);
    int total;
    int top;
    int bottom;
    if (slot >= WIN) slot = 0;
    ring[slot] = s;
    slot++;
    if (slot >= WIN) slot = 0;
    total = 0;
    top = -32768;
    bottom = 32767;
    foreach (ring[k]) begin
      if (int'(ring[k]) > top) top = ring[k];
      if (int'(ring[k]) < bottom) bottom = ring[k];
      total += ring[k];
    end
    return smp_t'((total - top - bottom) / (WIN - 2));
  endfunction

  task automatic report_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("error %0d at %0t: %s", mismatch_count, $realtime, msg);
  endtask

  task automatic push_sample(input smp_t s);
    int gap;
    gap = steady_in ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (in_stall);
    pending_filtered.push_back(trimmed_mean(s));
  endtask

  // result side back pressure
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (steady_out || $urandom_range(0, 3) != 0) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= 1'b1;
      stall_left <= pick_gap();
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_filtered.size() == 0) begin
        report_error($sformatf("unexpected result filtered=%0d", out_filtered));
      end else begin
        want_filtered = pending_filtered.pop_front();
        if (out_filtered !== want_filtered)
          report_error($sformatf("filtered expected %0d got %0d", want_filtered, out_filtered));
      end
    end
  end

  // entries not yet written still count as zero
  task automatic test_fresh_window();
    push_sample(SMP_MAX);
    push_sample(SMP_MIN);
    push_sample(16'sd1);
  endtask

  // whole window at one extreme: all entries tie and one entry is both max and min
  task automatic test_full_scale();
    repeat (WIN) push_sample(SMP_MAX);
    repeat (WIN) push_sample(SMP_MIN);
    push_sample(16'sh5555);
    push_sample(16'shaaaa);
  endtask

  task automatic test_random_full();
    steady_in = 1'b0;
    steady_out = 1'b0;
    repeat (400) push_sample(smp_t'($urandom_range(0, 65535)));
  endtask

  // few distinct values so ties on max and min are common
  task automatic test_random_ties();
    smp_t pick;
    for (int n = 0; n < 300; n++) begin
      steady_in = (n < 150);
      steady_out = (n < 150);
      case ($urandom_range(0, 5))
        0: pick = SMP_MAX;
        1: pick = SMP_MIN;
        2: pick = '0;
        3: pick = -16'sd1;
        4: pick = 16'sd1;
        default: pick = smp_t'($urandom_range(0, 65535));
      endcase
      push_sample(pick);
    end
  endtask

  // small values around zero check truncation of negative means
  task automatic test_random_small();
    steady_in = 1'b1;
    steady_out = 1'b0;
    for (int n = 0; n < 225; n++) begin
      if (n == 110) steady_in = 1'b0;
      if ($urandom_range(0, 9) == 0) push_sample(smp_t'($urandom_range(0, 65535)));
      else push_sample(smp_t'(int'($urandom_range(0, 600)) - 300));
    end
  endtask

  initial begin
    foreach (ring[k]) ring[k] = '0;
    slot = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_fresh_window();
    test_full_scale();
    test_random_full();
    test_random_ties();
    test_random_small();
    in_valid <= 1'b0;
    while (pending_filtered.size() != 0) @(posedge clk);
    repeat (4 * WIN + 20) @(posedge clk);
    if (mismatch_count == 0 && pending_filtered.size() == 0) begin
      $display("trimmed_moving_average_filter_test passed");
    end else begin
      $display("trimmed_moving_average_filter_test failed");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("trimmed_moving_average_filter_test failed");
    $finish;
  end

endmodule
